// ----- rtl/core/tli_pkg.sv -----
// Shared types and constants for the trajectory interpolator.
`default_nettype none
package tli_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int JOINTS_DEF = 12;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_INTERP = 2'd1;
  localparam logic [1:0] PH_END = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] point_time;
    logic [3:0]  joint_index;
    logic signed [15:0] position;
    logic [31:0] sample_time;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  joint_out;
    logic signed [15:0] desired_position;
    logic        valid_res;
    logic [1:0]  phase;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK_RD, ST_WALK_CHK, ST_TIME_RD, ST_TIME_LAT,
    ST_POS_RD, ST_POS_NXT, ST_POS_LAT, ST_DIV_SET, ST_DIV, ST_OUT, ST_EMPTY
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic clear;
    logic seg_reset;
    logic seg_inc;
    logic rd_next_time;
    logic rd_seg_times;
    logic lat_t0;
    logic lat_t1;
    logic rd_pos;
    logic lat_pos;
    logic div_start;
    logic div_step;
    logic out_load;
    logic out_empty;
    logic joint_inc;
    logic joint_clr;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic can_walk;
    logic walk_go;
    logic interp;
    logic div_done;
    logic last_joint;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/trajectory_linear_interpolator_top.sv -----
// Top level of the piecewise linear joint trajectory interpolator.
// Input channel in_valid/in_stall carries load, clear and sample words.
// A load, clear or unused-mode word is taken while idle and gives no output word.
// A sample walks the segment pointer point by point (a read and a check state for
// each point passed), reads the two segment times, then handles one joint at a time:
// reading positions and setting up, the bit-serial divider and loading the
// output word; the divider takes most of the time per joint.
// A sample holds in_stall until the last joint's word is loaded, and the next word
// can be taken in the cycle after that load.
// An empty table gives one word with valid_res low, loaded from the empty state.
// Output channel out_valid/out_stall: a held word stays until taken; a stall holds
// the controller in its output states and delays the load of the next word.
// Reset empties the table and puts the segment pointer back to minus one.
// Stored positions and times are not cleared.
`default_nettype none
module trajectory_linear_interpolator_top #(
  parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
  parameter int JOINTS = tli_pkg::JOINTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire tli_pkg::in_word_t in_word,
  output logic      out_valid,
  input  wire logic out_stall,
  output tli_pkg::out_word_t out_word
);
  import tli_pkg::*;
  cmd_t cmd;
  sts_t sts;

  tli_ctrl u_ctrl (.clk, .rst, .in_valid, .mode(in_word.mode), .in_stall,
                   .sts, .cmd);
  tli_datapath #(.MAX_POINTS(MAX_POINTS), .JOINTS(JOINTS)) u_dp (
    .clk, .rst, .in_word, .cmd, .sts, .out_valid, .out_stall, .out_word);
endmodule
`default_nettype wire

// ----- rtl/core/tli_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module tli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/tli_datapath.sv -----
// Table storage, segment walk, restoring divider and output register.
`default_nettype none
module tli_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int JOINTS = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tli_pkg::in_word_t  in_word,
  input  wire tli_pkg::cmd_t      cmd,
  output tli_pkg::sts_t           sts,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tli_pkg::out_word_t      out_word
);
  import tli_pkg::*;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int JW = $clog2(JOINTS) > 0 ? $clog2(JOINTS) : 1;
  localparam int PD = MAX_POINTS * JOINTS;
  localparam int AW = $clog2(PD);
  localparam int NW = 49; // |dp|(16) * num(32) doubled

  logic [CW-1:0] count;
  logic [CW:0]   seg;     // seg+1, so zero means minus one
  logic [JW-1:0] joint;
  logic          sel1;
  logic [31:0] t0, t1;
  logic signed [15:0] p0, p1;
  logic [31:0] trd;
  logic [15:0] prd;
  logic [PW-1:0] traddr;
  logic [AW-1:0] praddr, pwaddr;
  logic        pwe, twe;
  logic [NW-1:0] rem, numer;
  logic [NW-1:0] dens;
  logic [32:0]   den;
  logic [16:0]   q;
  logic [5:0]    step;
  logic          neg, bypass;
  logic signed [15:0] bypass_val;
  logic [CW-1:0] row;

  wire ld_ok = (count < CW'(MAX_POINTS)) &&
               (in_word.joint_index < 4'(JOINTS));
  assign pwe = cmd.load && ld_ok;
  assign twe = pwe && (in_word.joint_index == 4'(JOINTS - 1));
  assign pwaddr = AW'(count * JOINTS + in_word.joint_index);

  // row of the table for reading times / positions
  always_comb begin
    row = seg[CW-1:0];                     // next point index = seg+1-1+1
    traddr = PW'(seg[CW-1:0]);
    if (cmd.rd_seg_times) traddr = PW'(seg[CW-1:0] - CW'(sel1 ? 0 : 1));
    if (seg == '0) row = '0;
    else row = seg[CW-1:0] - CW'(1) + CW'(sel1);
    praddr = AW'(row * JOINTS + joint);
  end

  tli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_times (
    .clk, .we(twe), .waddr(PW'(count)), .wdata(in_word.point_time),
    .raddr(traddr), .rdata(trd));
  tli_ram #(.WIDTH(16), .DEPTH(PD)) u_pos (
    .clk, .we(pwe), .waddr(pwaddr), .wdata(in_word.position),
    .raddr(praddr), .rdata(prd));

  logic [31:0] stime;
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seg <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      else if (twe) count <= count + CW'(1);
      if (cmd.seg_reset) seg <= '0;
      else if (cmd.seg_inc) seg <= seg + (CW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_next_time) stime <= in_word.sample_time;
    if (cmd.lat_t0) t0 <= trd;
    if (cmd.lat_t1) t1 <= trd;
  end

  always_ff @(posedge clk) begin
    if (rst) sel1 <= 1'b0;
    else if (cmd.lat_pos || cmd.rd_next_time) sel1 <= 1'b0;
    else if (cmd.rd_pos) sel1 <= ~sel1;
  end

  // first rd_pos cycle addresses p0, second takes p0 and addresses p1,
  // lat_pos takes p1.
  always_ff @(posedge clk) begin
    if (cmd.rd_pos && sel1) p0 <= prd;
    if (cmd.lat_pos) p1 <= prd;
  end

  always_ff @(posedge clk) begin
    if (rst) joint <= '0;
    else if (cmd.joint_clr) joint <= '0;
    else if (cmd.joint_inc) joint <= joint + JW'(1);
  end

  // signed sample blend setup
  wire signed [33:0] num_s = $signed({2'b0, stime}) - $signed({2'b0, t0});
  wire signed [33:0] den_s = $signed({2'b0, t1}) - $signed({2'b0, t0});
  wire signed [16:0] diff = 17'(p1) - 17'(p0);
  wire [16:0] mag = diff[16] ? 17'(-diff) : diff;

  // restoring divider: q = (2*mag*num + den) / (2*den), one bit a cycle
  // product formed by one multiply at setup; the first step adds den to form numer
  logic [NW-1:0] acc;
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= diff[16];
      bypass <= (num_s <= 0) || (den_s <= 0) || (num_s >= den_s);
      bypass_val <= ((num_s <= 0) || (den_s <= 0)) ? p0 : p1;
      den <= den_s[32:0];
      acc <= NW'({mag, 1'b0}) * NW'(num_s[31:0]);
      step <= '0;
      q <= '0;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (step == 6'd0) begin
        numer <= acc + NW'(den);
        dens <= NW'({den, 1'b0});
        step <= 6'd1;
      end else begin
        rem <= ({rem[NW-2:0], numer[NW-1]} >= dens) ?
               ({rem[NW-2:0], numer[NW-1]} - dens) : {rem[NW-2:0], numer[NW-1]};
        numer <= {numer[NW-2:0], 1'b0};
        q <= {q[15:0], ({rem[NW-2:0], numer[NW-1]} >= dens)};
        step <= step + 6'd1;
      end
    end
  end
  assign sts.div_done = (step == 6'(NW + 1));

  logic signed [15:0] res;
  always_comb begin
    if (!sts.interp || bypass) res = sts.interp ? bypass_val : p0;
    else if (neg) res = 16'(p0 - $signed(q));
    else res = 16'(p0 + $signed(q));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load || cmd.out_empty) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_empty) out_word <= '{4'd0, 16'sd0, 1'b0, PH_BEFORE, 1'b1};
    else if (cmd.out_load)
      out_word <= '{4'(joint), res, 1'b1,
                    (seg == '0) ? PH_BEFORE : (sts.interp ? PH_INTERP : PH_END),
                    joint == JW'(JOINTS - 1)};
  end

  assign sts.empty = (count == '0);
  assign sts.can_walk = (CW'(seg) < count) && (seg[CW] == 1'b0);
  assign sts.walk_go = (trd < stime);
  assign sts.interp = (seg != '0) && ({1'b0, seg} < (CW+2)'(count));
  assign sts.last_joint = (joint == JW'(JOINTS - 1));
  assign sts.out_busy = out_valid && out_stall;
endmodule
`default_nettype wire

// ----- rtl/core/tli_ctrl.sv -----
// Sequencing state machine for load, clear and sample words.
`default_nettype none
module tli_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [1:0] mode,
  output logic      in_stall,
  input  wire tli_pkg::sts_t sts,
  output tli_pkg::cmd_t      cmd
);
  import tli_pkg::*;
  state_t state, state_next;
  wire acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (acc && mode == MODE_SAMPLE) state_next = sts.empty ? ST_EMPTY : ST_WALK_RD;
      ST_WALK_RD: state_next = sts.can_walk ? ST_WALK_CHK : ST_TIME_RD;
      ST_WALK_CHK: state_next = sts.walk_go ? ST_WALK_RD : ST_TIME_RD;
      ST_TIME_RD: state_next = ST_TIME_LAT;
      ST_TIME_LAT: state_next = ST_POS_RD;
      ST_POS_RD: state_next = ST_POS_NXT;
      ST_POS_NXT: state_next = ST_POS_LAT;
      ST_POS_LAT: state_next = ST_DIV_SET;
      ST_DIV_SET: state_next = ST_DIV;
      ST_DIV: if (sts.div_done) state_next = ST_OUT;
      ST_OUT:
        if (!sts.out_busy) state_next = sts.last_joint ? ST_IDLE : ST_POS_RD;
      ST_EMPTY: if (!sts.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.joint_clr = 1'b1;
        cmd.rd_next_time = acc;
        if (acc) begin
          cmd.load = (mode == MODE_LOAD);
          cmd.clear = (mode == MODE_CLEAR);
          cmd.seg_reset = (mode == MODE_LOAD) || (mode == MODE_CLEAR);
        end
      end
      ST_WALK_RD: ;
      ST_WALK_CHK: cmd.seg_inc = sts.walk_go;
      ST_TIME_RD: cmd.rd_seg_times = 1'b0;
      ST_TIME_LAT: begin
        cmd.lat_t1 = 1'b1;
        cmd.rd_seg_times = 1'b1;
      end
      // address t0 again so it can be taken with p0
      ST_POS_RD: begin
        cmd.rd_pos = 1'b1;
        cmd.rd_seg_times = 1'b1;
      end
      ST_POS_NXT: begin
        cmd.rd_pos = 1'b1;
        cmd.lat_t0 = 1'b1;
      end
      ST_POS_LAT: cmd.lat_pos = 1'b1;
      ST_DIV_SET: cmd.div_start = 1'b1;
      ST_DIV: cmd.div_step = !sts.div_done;
      ST_OUT: begin
        cmd.out_load = !sts.out_busy;
        cmd.joint_inc = !sts.out_busy;
      end
      ST_EMPTY: cmd.out_empty = !sts.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire
